### rtl/core/cbth_pkg.sv
// Shared types, constants and helpers for the chained block token hash.
// No dependencies; imported by every module of the block.
`default_nettype none

package cbth_pkg;

  localparam int unsigned TokenW    = 32;
  localparam int unsigned HashW     = 64;
  localparam int unsigned BlkNumW   = 16;
  localparam int unsigned BlkSizeW  = 11;
  localparam int unsigned MaxBlockTokens = 1024;
  localparam int unsigned CountW    = $clog2(MaxBlockTokens);

  localparam logic [HashW-1:0]    GoldenMix    = 64'h9E3779B97F4A7C15;
  localparam logic [BlkSizeW-1:0] BlkSizeReset = 11'd16;
  localparam logic [BlkSizeW-1:0] BlkSizeMax   = BlkSizeW'(MaxBlockTokens);
  localparam int unsigned         RotLeft      = 27;

  typedef struct packed {
    logic [TokenW-1:0] token;
    logic              seq_start;
    logic [HashW-1:0]  seed;
  } in_word_t;

  // Map the raw register to a usable block length: zero acts as one, clamp at the max.
  function automatic logic [BlkSizeW-1:0] eff_blk_len(input logic [BlkSizeW-1:0] raw);
    logic [BlkSizeW-1:0] sz;
    sz = raw;
    if (raw == '0) sz = BlkSizeW'(1);
    if (raw > BlkSizeMax) sz = BlkSizeMax;
    return sz;
  endfunction

endpackage : cbth_pkg

`default_nettype wire

### rtl/core/chained_block_token_hash_core.sv
// Chained block token hash: one token in per cycle unless stalled, one hash out per completed block.
// Holds the input register and the block length register.
// Depends on cbth_pkg and cbth_chain.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one token word: token_i,
//   seq_start_i and seed_i. A word is taken at a clock edge with in_valid_i
//   high and in_stall_o low. Tokens are hashed in blocks of the configured length.
//   Output channel (out_valid_o / out_stall_i) carries block_hash_o and
//   block_number_o, one word per completed block.
//   Path: a word that completes a block is loaded into the input register
//   when taken, then the hash round runs into the result register once
//   the chain is ready (no held result stalled by the receiver).
//   Throughput: one token per cycle while the receiver does not stall;
//   the hash round (xor, shift-add multiply by the FNV prime, rotate) is combinational.
//   Reset clears the hash chain, counters and valids and sets the block
//   length to 16; the chain starts from parent 0 until a seq_start word arrives.
//   While the receiver stalls a held result, the result holds; the word in
//   the input register waits and in_stall_o rises, so nothing is lost.
//   cfg_we_i writes the block length from cfg_wdata_i; write only while idle.
`default_nettype none

module chained_block_token_hash_core
  import cbth_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [BlkSizeW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [TokenW-1:0]   token_i,
  input  logic                seq_start_i,
  input  logic [HashW-1:0]    seed_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [HashW-1:0]    block_hash_o,
  output logic [BlkNumW-1:0]  block_number_o
);

  logic [BlkSizeW-1:0] blk_len_q, blk_len_d;
  logic                in_valid_q, in_valid_d;
  in_word_t            in_word_q;
  logic                chain_ready;
  logic                fire;
  logic                take;

  assign fire       = in_valid_q && chain_ready;
  assign in_stall_o = in_valid_q && !chain_ready;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    blk_len_d  = cfg_we_i ? cfg_wdata_i : blk_len_q;
    in_valid_d = take || (in_valid_q && !fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_len_q  <= BlkSizeReset;
      in_valid_q <= 1'b0;
    end else begin
      blk_len_q  <= blk_len_d;
      in_valid_q <= in_valid_d;
    end
  end

  // hold the word until the chain takes it
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_word_q.token     <= token_i;
      in_word_q.seq_start <= seq_start_i;
      in_word_q.seed      <= seed_i;
    end
  end

  cbth_chain u_chain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .word_i         (in_word_q),
    .blk_len_i      (blk_len_q),
    .ready_o        (chain_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .block_hash_o   (block_hash_o),
    .block_number_o (block_number_o)
  );

endmodule : chained_block_token_hash_core

`default_nettype wire

### rtl/core/cbth_mix.sv
// One hash round: xor in the token, multiply by the 64-bit FNV prime, rotate left.
// Depends on cbth_pkg.
`default_nettype none

module cbth_mix
  import cbth_pkg::*;
(
  input  logic [HashW-1:0]  hash_i,
  input  logic [TokenW-1:0] token_i,
  output logic [HashW-1:0]  hash_o
);

  logic [HashW-1:0] x;
  logic [HashW-1:0] prod;

  assign x = hash_i ^ {{(HashW-TokenW){1'b0}}, token_i};

  // prime = 2^40 + 0x1B3, and 0x1B3 = 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1
  assign prod = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;

  assign hash_o = {prod[HashW-RotLeft-1:0], prod[HashW-1:HashW-RotLeft]};

endmodule : cbth_mix

`default_nettype wire

### rtl/core/cbth_chain.sv
// Chaining state (running hash, parent, counters) and the result register.
// Depends on cbth_pkg and cbth_mix.
`default_nettype none

module cbth_chain
  import cbth_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  in_word_t            word_i,
  input  logic [BlkSizeW-1:0] blk_len_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [HashW-1:0]    block_hash_o,
  output logic [BlkNumW-1:0]  block_number_o
);

  logic [HashW-1:0]   run_q, run_d;
  logic [HashW-1:0]   parent_q, parent_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [BlkNumW-1:0] blocks_q, blocks_d;
  logic               out_valid_q, out_valid_d;
  logic [HashW-1:0]   block_hash_q;
  logic [BlkNumW-1:0] block_number_q;

  logic [HashW-1:0]    parent_eff;
  logic [CountW-1:0]   cnt_eff;
  logic [BlkNumW-1:0]  blocks_eff;
  logic [BlkSizeW-1:0] cnt_inc;
  logic [HashW-1:0]    base;
  logic [HashW-1:0]    hash_new;
  logic [HashW-1:0]    final_hash;
  logic                done;

  // sequence start drops any partial block and reloads the parent
  assign parent_eff = word_i.seq_start ? word_i.seed : parent_q;
  assign cnt_eff    = word_i.seq_start ? '0 : cnt_q;
  assign blocks_eff = word_i.seq_start ? '0 : blocks_q;
  assign base       = (cnt_eff == '0) ? (parent_eff ^ GoldenMix) : run_q;

  cbth_mix u_mix (
    .hash_i  (base),
    .token_i (word_i.token),
    .hash_o  (hash_new)
  );

  assign cnt_inc    = {1'b0, cnt_eff} + BlkSizeW'(1);
  assign done       = cnt_inc >= eff_blk_len(blk_len_i);
  assign final_hash = (hash_new == '0) ? HashW'(1) : hash_new;

  assign ready_o = !out_valid_q || !out_stall_i;

  always_comb begin
    run_d       = run_q;
    parent_d    = parent_q;
    cnt_d       = cnt_q;
    blocks_d    = blocks_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (fire_i) begin
      if (done) begin
        parent_d    = final_hash;
        run_d       = '0;
        cnt_d       = '0;
        blocks_d    = blocks_eff + BlkNumW'(1);
        out_valid_d = 1'b1;
      end else begin
        parent_d = parent_eff;
        run_d    = hash_new;
        cnt_d    = cnt_inc[CountW-1:0];
        blocks_d = blocks_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      parent_q    <= '0;
      cnt_q       <= '0;
      blocks_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      parent_q    <= parent_d;
      cnt_q       <= cnt_d;
      blocks_q    <= blocks_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload: load only when a block completes
  always_ff @(posedge clk_i) begin
    if (fire_i && done) begin
      block_hash_q   <= final_hash;
      block_number_q <= blocks_eff;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign block_hash_o   = block_hash_q;
  assign block_number_o = block_number_q;

`ifndef NO_ASSERTIONS
  a_done_shows_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && done |=> out_valid_q)
    else $error("completed block did not raise the result");

  a_hash_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> block_hash_q != '0)
    else $error("zero block hash presented");

  a_partial_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !done |=> cnt_q != '0)
    else $error("token count lost on a partial block");

  a_no_fire_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && fire_i |-> !done)
    else $error("completed block would overwrite a held result");
`endif

endmodule : cbth_chain

`default_nettype wire

### test/tb_chained_block_token_hash_core.sv
// Self-checking testbench for chained_block_token_hash_core: directed and random token
// streams, with block hashes predicted in a small scoreboard class.
// Depends on cbth_pkg and the core RTL.

module tb_chained_block_token_hash_core;
  import cbth_pkg::*;

  localparam logic [HashW-1:0] FnvPrime     = 64'h0000_0100_0000_01B3;
  localparam int unsigned      SettleCycles = 4;
  localparam int unsigned      CycleLimit   = 1_000_000;
  localparam int unsigned      LongHold     = 300;

  typedef struct packed {
    logic [HashW-1:0]   hash;
    logic [BlkNumW-1:0] number;
  } blk_result_t;

  class block_hash_scoreboard;
    logic [BlkSizeW-1:0] blk_size;
    logic [HashW-1:0]    run_hash;
    logic [HashW-1:0]    parent_hash;
    int unsigned         tok_count;
    logic [BlkNumW-1:0]  blk_count;
    blk_result_t         expected_q[$];
    int unsigned         errors;

    function new();
      blk_size    = BlkSizeReset;
      run_hash    = '0;
      parent_hash = '0;
      tok_count   = 0;
      blk_count   = '0;
      errors      = 0;
    endfunction

    function void set_blk_len(logic [BlkSizeW-1:0] v);
      blk_size = v;
    endfunction

    function int unsigned eff_size();
      if (blk_size == '0) return 1;
      if (blk_size > MaxBlockTokens) return MaxBlockTokens;
      return blk_size;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Advance the chain by one accepted token word.
    function void note_word(in_word_t w);
      logic [HashW-1:0] h;
      blk_result_t      r;
      if (w.seq_start) begin
        parent_hash = w.seed;
        tok_count   = 0;
        blk_count   = '0;
      end
      h = (tok_count == 0) ? (parent_hash ^ GoldenMix) : run_hash;
      h = (h ^ HashW'(w.token)) * FnvPrime;
      h = (h << RotLeft) | (h >> (HashW - RotLeft));
      run_hash  = h;
      tok_count = tok_count + 1;
      if (tok_count >= eff_size()) begin
        r.hash   = (h == '0) ? HashW'(1) : h;
        r.number = blk_count;
        expected_q.insert(expected_q.size(), r);
        parent_hash = r.hash;
        run_hash    = '0;
        tok_count   = 0;
        blk_count   = blk_count + 1'b1;
      end
    endfunction

    function void check_result(logic [HashW-1:0] hash, logic [BlkNumW-1:0] number);
      blk_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: block_hash %h block_number %0d", hash, number);
        errors++;
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      if (hash !== e.hash) begin
        $error("block_hash mismatch: expected %h, actual %h", e.hash, hash);
        errors++;
      end
      if (number !== e.number) begin
        $error("block_number mismatch: expected %0d, actual %0d", e.number, number);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [BlkSizeW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [TokenW-1:0]   token_i;
  logic                seq_start_i;
  logic [HashW-1:0]    seed_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [HashW-1:0]    block_hash_o;
  logic [BlkNumW-1:0]  block_number_o;

  block_hash_scoreboard sb;
  bit                   quiet;
  bit                   hold_req;
  bit                   tx_calm;
  int unsigned          tx_mode_left;
  int unsigned          cycle_count;
  int unsigned          phase_sizes[12] = '{2, 1, 5, 16, 0, 7, 3, 9, 4, 6, 12, 8};

  chained_block_token_hash_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .token_i        (token_i),
    .seq_start_i    (seq_start_i),
    .seed_i         (seed_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .block_hash_o   (block_hash_o),
    .block_number_o (block_number_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [HashW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TokenW-1:0] rand_token();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  function automatic in_word_t mk_word(logic [TokenW-1:0] tok, logic st, logic [HashW-1:0] sd);
    in_word_t w;
    w.token     = tok;
    w.seq_start = st;
    w.seed      = sd;
    return w;
  endfunction

  // Offer one word and hold it until the core takes it.
  task automatic send_word(in_word_t w);
    int unsigned gap;
    if (tx_mode_left == 0) begin
      tx_calm      = ($urandom_range(0, 3) == 0);
      tx_mode_left = $urandom_range(20, 150);
    end
    tx_mode_left--;
    gap = (quiet || tx_calm) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    token_i     <= w.token;
    seq_start_i <= w.seq_start;
    seed_i      <= w.seed;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_word(w);
  endtask

  task automatic send_run(int unsigned n);
    repeat (n) send_word(mk_word(rand_token(), 1'b0, rand64()));
  endtask

  // Well-formed sequences with random content, a few broken by an early restart.
  task automatic send_stream(int unsigned n);
    int unsigned left;
    int unsigned r;
    in_word_t    w;
    left = 0;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (left == 0 || r < 3) begin
        w.seq_start = 1'b1;
        r = $urandom_range(0, 9);
        if (r < 4) w.seed = '0;
        else if (r < 8) w.seed = rand64();
        else w.seed = sb.parent_hash;
        left = $urandom_range(1, sb.eff_size() * 3 + 2);
      end else begin
        w.seq_start = 1'b0;
        w.seed      = rand64();
      end
      w.token = rand_token();
      send_word(w);
      left--;
      // hold off the sender until the core has delivered everything
      if ($urandom_range(0, 149) == 0 && sb.pending() != 0) begin
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_blk_len(logic [BlkSizeW-1:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_blk_len(v);
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned mode_left;
    bit          rx_calm;
    stall_left  = 0;
    hold_left   = 0;
    mode_left   = 0;
    rx_calm     = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0)
        sb.check_result(block_hash_o, block_number_o);
      if (hold_req) begin
        hold_left = LongHold;
        hold_req  = 1'b0;
      end
      if (mode_left == 0) begin
        rx_calm   = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (stall_left == 0 && !quiet && !rx_calm) stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    bit held;
    held         = 1'b0;
    sb           = new();
    quiet        = 1'b0;
    hold_req     = 1'b0;
    tx_calm      = 1'b0;
    tx_mode_left = 0;
    cycle_count  = 0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    token_i      = '0;
    seq_start_i  = 1'b0;
    seed_i       = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset block size, no sequence start yet: chain from parent zero.
    send_word(mk_word('0, 1'b0, '1));
    send_word(mk_word('1, 1'b0, '0));
    send_run(14);
    drain();

    // Zero size acts as one word per block.
    write_blk_len('0);
    send_word(mk_word('1, 1'b1, '0));
    // seed cancels the first round to zero; the emitted hash must read one
    send_word(mk_word(32'h0000_1234, 1'b1, GoldenMix ^ 64'h1234));
    send_word(mk_word('0, 1'b0, '1));
    drain();

    // Restart mid-block drops the partial block.
    write_blk_len(11'd3);
    send_word(mk_word('0, 1'b1, '1));
    send_word(mk_word($urandom, 1'b0, '0));
    send_word(mk_word('1, 1'b1, rand64()));
    send_run(2);
    // leave two words in the block, then shrink the block under them
    send_run(2);
    drain();
    write_blk_len(11'd1);
    send_run(1);
    drain();

    foreach (phase_sizes[i]) begin
      write_blk_len(BlkSizeW'(phase_sizes[i]));
      if (phase_sizes[i] == 1 && !held) begin
        // stall the receiver long enough for the core to back up into the sender
        quiet    = 1'b1;
        hold_req = 1'b1;
        held     = 1'b1;
      end
      send_stream(78);
      quiet = 1'b0;
      drain();
    end

    // Register value above the cap: no block may complete early.
    write_blk_len('1);
    send_word(mk_word(rand_token(), 1'b1, rand64()));
    send_run(39);
    drain();
    // lower the length under the partial block; the next word completes it
    write_blk_len(11'd2);
    send_run(1);
    drain();

    repeat (16) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### chained_block_token_hash_core.f
rtl/core/cbth_pkg.sv
rtl/core/cbth_mix.sv
rtl/core/cbth_chain.sv
rtl/core/chained_block_token_hash_core.sv
test/tb_chained_block_token_hash_core.sv
